FILE: design/mse_pkg.sv
// mse_pkg: shared types and constants for the measurement statistics engine.
// Used by measurement_statistics_engine and mse_checker.
package mse_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = 5;
  localparam int VAL_W       = 16;
  // sum of MAX_ENTRIES signed values
  localparam int SUM_W       = VAL_W + IDX_W + 1;
  // sum of MAX_ENTRIES squared deviations (each below 2^32)
  localparam int SQ_W        = 2 * VAL_W + IDX_W + 1;

  localparam logic [1:0] REQ_WR_TEMP  = 2'd0;
  localparam logic [1:0] REQ_WR_HUMID = 2'd1;
  localparam logic [1:0] REQ_QUERY    = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic                    status;
    logic signed [VAL_W-1:0] humidity_max;
    logic [IDX_W-1:0]        humidity_max_index;
    logic signed [VAL_W-1:0] humidity_min;
    logic [IDX_W-1:0]        humidity_min_index;
    logic signed [VAL_W-1:0] temperature_mean;
    logic signed [VAL_W-1:0] humidity_mean;
    logic [VAL_W-1:0]        humidity_std_dev;
  } out_word_t;

endpackage

FILE: design/mse_ram.sv
// mse_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/measurement_statistics_engine.sv
// measurement_statistics_engine: temperature and humidity tables with statistics.
// Depends on mse_pkg and mse_ram.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one request word: write
//   temperature, write humidity, or query. out channel (out_valid/out_ready/
//   out_data) returns exactly one result word per request, in order.
//   cfg_wr_en/cfg_wr_data set entry_count (write only while idle).
// Sequencing:
//   A write result is registered in the sequencer, then in the output register.
//   A query for n active entries makes two table passes of n reads each
//   through the RAM read port, two 20-step mean divisions and one 37-step
//   variance division on a shared restoring divider, then a 16-step square
//   root.
//   One request is worked at a time; in_ready is high only when the sequencer
//   is idle, and the next request is taken while a result still waits.
// Reset: both tables read as zero (per-entry valid bits cleared), entry_count
//   returns to 1, the output register empties.
// Stall: if out_ready is low, the finished result waits in the output register
//   and the next finished result waits in the sequencer until it drains.
module measurement_statistics_engine import mse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  localparam int DIV_W    = SQ_W;
  localparam int DCNT_W   = $clog2(DIV_W + 1);
  localparam int ROOT_W   = VAL_W;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int RCNT_W   = $clog2(ROOT_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1   = 3'd1;
  localparam logic [2:0] S_DIVT = 3'd2;
  localparam logic [2:0] S_DIVH = 3'd3;
  localparam logic [2:0] S_P2   = 3'd4;
  localparam logic [2:0] S_DIVV = 3'd5;
  localparam logic [2:0] S_SQRT = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]              state;
  logic [CNT_W-1:0]        entry_count;
  logic [MAX_ENTRIES-1:0]  t_valid, h_valid;
  logic [CNT_W-1:0]        ai;
  logic                    p_vld, m_vld;
  logic [IDX_W-1:0]        p_idx;
  logic                    vt_q, vh_q;
  logic [VAL_W-1:0]        t_rd, h_rd;
  logic signed [SUM_W-1:0] sum_t, sum_h;
  logic [SQ_W-1:0]         sq;
  logic [2*VAL_W-1:0]      prod;
  out_word_t               res;
  logic [DIV_W-1:0]        dv_q;
  logic [CNT_W-1:0]        dv_r;
  logic [DCNT_W-1:0]       dv_cnt;
  logic [RAD_W-1:0]        sx;
  logic [REM_W-1:0]        sr_rem;
  logic [ROOT_W-1:0]       sr_root;
  logic [RCNT_W-1:0]       sr_cnt;

  // active count clamped to 1..MAX_ENTRIES
  logic [CNT_W-1:0] n;
  always_comb begin
    if (entry_count == '0) begin
      n = CNT_W'(1);
    end else if (entry_count > CNT_W'(MAX_ENTRIES)) begin
      n = CNT_W'(MAX_ENTRIES);
    end else begin
      n = entry_count;
    end
  end

  logic accept, idx_ok, we_t, we_h;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = {1'b0, in_data.entry_index} < n;
  assign we_t     = accept && in_data.req_type == REQ_WR_TEMP && idx_ok;
  assign we_h     = accept && in_data.req_type == REQ_WR_HUMID && idx_ok;

  mse_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_temp_ram (
    .clk   (clk),
    .we    (we_t),
    .waddr (in_data.entry_index),
    .wdata (in_data.new_value),
    .raddr (ai[IDX_W-1:0]),
    .rdata (t_rd)
  );

  mse_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_humid_ram (
    .clk   (clk),
    .we    (we_h),
    .waddr (in_data.entry_index),
    .wdata (in_data.new_value),
    .raddr (ai[IDX_W-1:0]),
    .rdata (h_rd)
  );

  // entries never written read as zero
  logic signed [VAL_W-1:0] t_cur, h_cur;
  assign t_cur = vt_q ? t_rd : '0;
  assign h_cur = vh_q ? h_rd : '0;

  logic signed [VAL_W:0]     dev;
  logic signed [2*VAL_W+1:0] dev_sq;
  assign dev    = {h_cur[VAL_W-1], h_cur} - {res.humidity_mean[VAL_W-1], res.humidity_mean};
  assign dev_sq = dev * dev;

  logic [SUM_W-1:0] abs_t, abs_h;
  assign abs_t = sum_t[SUM_W-1] ? SUM_W'(-sum_t) : sum_t;
  assign abs_h = sum_h[SUM_W-1] ? SUM_W'(-sum_h) : sum_h;

  // restoring divide step, divisor n
  logic [CNT_W:0] dv_t, dv_s;
  logic           dv_ge;
  assign dv_t  = {dv_r, dv_q[DIV_W-1]};
  assign dv_ge = dv_t >= {1'b0, n};
  assign dv_s  = dv_ge ? (dv_t - {1'b0, n}) : dv_t;

  // square root step, two radicand bits per cycle
  logic [REM_W+1:0] sr_t, sr_trial;
  logic             sr_ge;
  assign sr_t     = {sr_rem, sx[RAD_W-1 -: 2]};
  assign sr_trial = {2'b00, sr_root, 2'b01};
  assign sr_ge    = sr_t >= sr_trial;

  logic [VAL_W-1:0] q_lo;
  assign q_lo = dv_q[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      entry_count <= CNT_W'(1);
      t_valid     <= '0;
      h_valid     <= '0;
      ai          <= '0;
      p_vld       <= 1'b0;
      m_vld       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_count <= cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (we_t) t_valid[in_data.entry_index] <= 1'b1;
      if (we_h) h_valid[in_data.entry_index] <= 1'b1;
      p_vld <= 1'b0;
      m_vld <= 1'b0;
      vt_q  <= t_valid[ai[IDX_W-1:0]];
      vh_q  <= h_valid[ai[IDX_W-1:0]];

      case (state)
        S_IDLE: begin
          if (accept) begin
            sum_t <= '0;
            sum_h <= '0;
            sq    <= '0;
            ai    <= '0;
            if (in_data.req_type == REQ_QUERY) begin
              res   <= '0;
              state <= S_P1;
            end else begin
              res   <= '{status: !(in_data.req_type inside {REQ_WR_TEMP, REQ_WR_HUMID})
                                 || !idx_ok,
                         default: '0};
              state <= S_DONE;
            end
          end
        end
        S_P1: begin
          if (ai < n) begin
            ai    <= ai + CNT_W'(1);
            p_vld <= 1'b1;
            p_idx <= ai[IDX_W-1:0];
          end
          if (p_vld) begin
            sum_t <= sum_t + SUM_W'(t_cur);
            sum_h <= sum_h + SUM_W'(h_cur);
            if (p_idx == '0) begin
              res.humidity_max       <= h_cur;
              res.humidity_min       <= h_cur;
              res.humidity_max_index <= '0;
              res.humidity_min_index <= '0;
            end else begin
              if (h_cur > res.humidity_max) begin
                res.humidity_max       <= h_cur;
                res.humidity_max_index <= p_idx;
              end
              if (h_cur < res.humidity_min) begin
                res.humidity_min       <= h_cur;
                res.humidity_min_index <= p_idx;
              end
            end
          end
          if (ai == n && !p_vld) begin
            dv_q   <= {abs_t[SUM_W-2:0], {(DIV_W-SUM_W+1){1'b0}}};
            dv_r   <= '0;
            dv_cnt <= DCNT_W'(SUM_W - 1);
            state  <= S_DIVT;
          end
        end
        S_DIVT: begin
          if (dv_cnt != '0) begin
            dv_q   <= {dv_q[DIV_W-2:0], dv_ge};
            dv_r   <= dv_s[CNT_W-1:0];
            dv_cnt <= dv_cnt - DCNT_W'(1);
          end else begin
            res.temperature_mean <= sum_t[SUM_W-1] ? (~q_lo) + VAL_W'(1) : q_lo;
            dv_q   <= {abs_h[SUM_W-2:0], {(DIV_W-SUM_W+1){1'b0}}};
            dv_r   <= '0;
            dv_cnt <= DCNT_W'(SUM_W - 1);
            state  <= S_DIVH;
          end
        end
        S_DIVH: begin
          if (dv_cnt != '0) begin
            dv_q   <= {dv_q[DIV_W-2:0], dv_ge};
            dv_r   <= dv_s[CNT_W-1:0];
            dv_cnt <= dv_cnt - DCNT_W'(1);
          end else begin
            res.humidity_mean <= sum_h[SUM_W-1] ? (~q_lo) + VAL_W'(1) : q_lo;
            ai    <= '0;
            state <= S_P2;
          end
        end
        S_P2: begin
          if (ai < n) begin
            ai    <= ai + CNT_W'(1);
            p_vld <= 1'b1;
          end
          if (p_vld) begin
            prod  <= dev_sq[2*VAL_W-1:0];
            m_vld <= 1'b1;
          end
          if (m_vld) begin
            sq <= sq + SQ_W'(prod);
          end
          if (ai == n && !p_vld && !m_vld) begin
            dv_q   <= sq;
            dv_r   <= '0;
            dv_cnt <= DCNT_W'(DIV_W);
            state  <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (dv_cnt != '0) begin
            dv_q   <= {dv_q[DIV_W-2:0], dv_ge};
            dv_r   <= dv_s[CNT_W-1:0];
            dv_cnt <= dv_cnt - DCNT_W'(1);
          end else begin
            // variance is below 2^32
            sx      <= dv_q[RAD_W-1:0];
            sr_rem  <= '0;
            sr_root <= '0;
            sr_cnt  <= RCNT_W'(ROOT_W);
            state   <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sr_cnt != '0) begin
            sr_rem  <= sr_ge ? REM_W'(sr_t - sr_trial) : REM_W'(sr_t);
            sr_root <= {sr_root[ROOT_W-2:0], sr_ge};
            sx      <= {sx[RAD_W-3:0], 2'b00};
            sr_cnt  <= sr_cnt - RCNT_W'(1);
          end else begin
            res.humidity_std_dev <= sr_root;
            state                <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/mse_checker.sv
// mse_checker: port-level assertions for measurement_statistics_engine.
// Depends on mse_pkg; bound to the top level below.
module mse_checker import mse_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // refused results (status set) carry no statistics
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |->
      out_data.humidity_max == '0 && out_data.humidity_min == '0 &&
      out_data.temperature_mean == '0 && out_data.humidity_mean == '0 &&
      out_data.humidity_std_dev == '0)
    else $error("status result carries statistics");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.humidity_min <= out_data.humidity_max)
    else $error("humidity min above max");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind measurement_statistics_engine mse_checker u_mse_checker (.*);

FILE: verif/tb_measurement_statistics_engine.sv
// Testbench for measurement_statistics_engine: table writes and statistics queries,
// checked against an in-bench predictor. Depends on mse_pkg and the design files.
`timescale 1ns / 100ps

module tb_measurement_statistics_engine;
  import mse_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  measurement_statistics_engine u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic signed [VAL_W-1:0] temp_tbl [MAX_ENTRIES];
  logic signed [VAL_W-1:0] humid_tbl [MAX_ENTRIES];
  logic [CNT_W-1:0] count_reg;

  in_word_t pending_words[$];
  out_word_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit idle_free = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic out_word_t apply_request(in_word_t w);
    out_word_t r;
    int n, imax, imin;
    longint hmax, hmin, sum_t, sum_h, mt, mh, d;
    longint unsigned sq;
    r = '0;
    n = count_reg;
    if (n < 1) n = 1;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    if (w.req_type == REQ_WR_TEMP || w.req_type == REQ_WR_HUMID) begin
      if (w.entry_index >= n) r.status = 1'b1;
      else if (w.req_type == REQ_WR_TEMP) temp_tbl[w.entry_index] = w.new_value;
      else humid_tbl[w.entry_index] = w.new_value;
    end else if (w.req_type == REQ_UNUSED) begin
      r.status = 1'b1;
    end else begin
      hmax = humid_tbl[0];
      hmin = hmax;
      imax = 0;
      imin = 0;
      sum_t = 0;
      sum_h = 0;
      for (int i = 0; i < n; i++) begin
        if (humid_tbl[i] > hmax) begin hmax = humid_tbl[i]; imax = i; end
        if (humid_tbl[i] < hmin) begin hmin = humid_tbl[i]; imin = i; end
        sum_h += humid_tbl[i];
        sum_t += temp_tbl[i];
      end
      mt = sum_t / n;  // truncates toward zero
      mh = sum_h / n;
      sq = 0;
      for (int i = 0; i < n; i++) begin
        d = humid_tbl[i] - mh;
        if (d < 0) d = -d;
        sq += longint'(d * d);
      end
      r.humidity_max = hmax[15:0];
      r.humidity_max_index = imax[3:0];
      r.humidity_min = hmin[15:0];
      r.humidity_min_index = imin[3:0];
      r.temperature_mean = mt[15:0];
      r.humidity_mean = mh[15:0];
      r.humidity_std_dev = VAL_W'(int_sqrt(sq / n));
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_request(in_data));
        void'(pending_words.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold the word
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        // the accepted word is already popped, so the head is the next one
        in_valid <= 1'b1;
        in_data <= pending_words[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status); errors++; end
          if (out_data.humidity_max !== e.humidity_max) begin
            $error("humidity_max exp %0d got %0d", e.humidity_max, out_data.humidity_max);
            errors++; end
          if (out_data.humidity_max_index !== e.humidity_max_index) begin
            $error("humidity_max_index exp %0d got %0d", e.humidity_max_index,
                   out_data.humidity_max_index); errors++; end
          if (out_data.humidity_min !== e.humidity_min) begin
            $error("humidity_min exp %0d got %0d", e.humidity_min, out_data.humidity_min);
            errors++; end
          if (out_data.humidity_min_index !== e.humidity_min_index) begin
            $error("humidity_min_index exp %0d got %0d", e.humidity_min_index,
                   out_data.humidity_min_index); errors++; end
          if (out_data.temperature_mean !== e.temperature_mean) begin
            $error("temperature_mean exp %0d got %0d", e.temperature_mean,
                   out_data.temperature_mean); errors++; end
          if (out_data.humidity_mean !== e.humidity_mean) begin
            $error("humidity_mean exp %0d got %0d", e.humidity_mean, out_data.humidity_mean);
            errors++; end
          if (out_data.humidity_std_dev !== e.humidity_std_dev) begin
            $error("humidity_std_dev exp %0d got %0d", e.humidity_std_dev,
                   out_data.humidity_std_dev); errors++; end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (!idle_free && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("measurement_statistics_engine verification failed");
      $finish;
    end
  end

  function automatic in_word_t make_word(logic [1:0] req, int idx, int val);
    in_word_t w;
    w.req_type = req;
    w.entry_index = idx[3:0];
    w.new_value = val[15:0];
    return w;
  endfunction

  function automatic int rand_value();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(int c);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c[CNT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    count_reg = c[CNT_W-1:0];
  endtask

  initial begin
    int counts[8] = '{16, 0, 1, 31, 17, 5, 2, 9};
    int c;
    for (int i = 0; i < MAX_ENTRIES; i++) begin temp_tbl[i] = 0; humid_tbl[i] = 0; end
    count_reg = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: query on cleared tables, extremes, ties, bad index, unused type
    pending_words.push_back(make_word(REQ_QUERY, 0, 0));
    pending_words.push_back(make_word(REQ_WR_TEMP, 1, 5));      // refused at count 1
    pending_words.push_back(make_word(REQ_UNUSED, 15, -1));
    pending_words.push_back(make_word(REQ_WR_HUMID, 0, -32768));
    pending_words.push_back(make_word(REQ_QUERY, 15, 32767));
    drain();
    set_count(16);
    for (int i = 0; i < 4; i++) begin
      pending_words.push_back(make_word(REQ_WR_HUMID, 15 - i, (i % 2) ? 32767 : -32768));
      pending_words.push_back(make_word(REQ_WR_TEMP, i, -32768));
    end
    pending_words.push_back(make_word(REQ_WR_TEMP, 15, 32767));
    pending_words.push_back(make_word(REQ_WR_HUMID, 3, 32767)); // tie, lower index
    pending_words.push_back(make_word(REQ_QUERY, 0, 0));
    pending_words.push_back(make_word(REQ_UNUSED, 0, 0));
    pending_words.push_back(make_word(REQ_QUERY, 7, -7));
    drain();  // sender holds until all results are back

    for (int p = 0; p < 8; p++) begin
      set_count(counts[p]);
      c = counts[p] < 1 ? 1 : (counts[p] > 16 ? 16 : counts[p]);
      if (p == 7) idle_free = 1'b1;
      for (int k = 0; k < 150; k++) begin
        case ($urandom_range(0, 19))
          0: pending_words.push_back(make_word(REQ_UNUSED, $urandom_range(0, 15),
                                               rand_value()));
          1, 2, 3: pending_words.push_back(make_word(REQ_QUERY, $urandom_range(0, 15),
                                                     rand_value()));
          default: pending_words.push_back(make_word(2'($urandom_range(0, 1)),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, c - 1),
                     rand_value()));
        endcase
      end
      drain();
    end
    repeat (200) @(posedge clk);
    if (errors == 0) $display("measurement_statistics_engine verification clean");
    else $display("measurement_statistics_engine verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/mse_pkg.sv
design/mse_ram.sv
design/measurement_statistics_engine.sv
design/mse_checker.sv
verif/tb_measurement_statistics_engine.sv
